FILE: rtl/sdrc_pkg.sv
// Package with shared types, constants and calendar functions of the stay date range checker.
package sdrc_pkg;

    // Field widths.
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int SERIAL_W = 22;
    localparam int MTERM_W  = 9;

    // Year limits and the reset value of the minimum year register.
    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd2024;
    localparam logic [YEAR_W-1:0] YEAR_MAX       = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_FLOOR     = 14'd1;

    // Division by 100 through a reciprocal: exact for every 14-bit year.
    localparam int DIV100_PROD_W = 27;
    localparam int DIV100_SHIFT  = 19;
    localparam int CENT_W        = DIV100_PROD_W - DIV100_SHIFT;
    localparam logic [DIV100_PROD_W-1:0] DIV100_MUL = 27'd5243;
    localparam logic [YEAR_W-1:0]        CENTURY    = 14'd100;
    localparam logic [SERIAL_W-1:0]      DAYS_YEAR  = 22'd365;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ARR_BAD = 2'd1,
        STATUS_DEP_BAD = 2'd2,
        STATUS_ORDER   = 2'd3
    } t_status;

    // Evaluation of one date, passed from the date unit to the top level.
    typedef struct packed {
        logic                valid;
        logic [SERIAL_W-1:0] serial;
    } t_date_eval;

    // Month term (153*m + 2)/5 of the March-based count, with January and
    // February taken as months 13 and 14 of the previous year.
    function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] month);
        logic [MTERM_W-1:0] term;
        case (month)
            4'd1:    term = 9'd398;
            4'd2:    term = 9'd428;
            4'd3:    term = 9'd92;
            4'd4:    term = 9'd122;
            4'd5:    term = 9'd153;
            4'd6:    term = 9'd184;
            4'd7:    term = 9'd214;
            4'd8:    term = 9'd245;
            4'd9:    term = 9'd275;
            4'd10:   term = 9'd306;
            4'd11:   term = 9'd337;
            4'd12:   term = 9'd367;
            default: term = 9'd0;
        endcase
        return term;
    endfunction

    // Last valid day of a month; zero for a month number outside the year.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic              leap);
        logic [DAY_W-1:0] days;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
            4'd2:    days = leap ? 5'd29 : 5'd28;
            default: days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

FILE: rtl/sdrc_if.sv
// Handshake interfaces for the date pair words and the result words.
interface sdrc_in_if;
    logic                               valid;
    logic                               ready;
    logic [sdrc_pkg::DAY_W-1:0]         arrival_day;
    logic [sdrc_pkg::MONTH_W-1:0]       arrival_month;
    logic [sdrc_pkg::YEAR_W-1:0]        arrival_year;
    logic [sdrc_pkg::DAY_W-1:0]         departure_day;
    logic [sdrc_pkg::MONTH_W-1:0]       departure_month;
    logic [sdrc_pkg::YEAR_W-1:0]        departure_year;

    modport source (
        output valid, arrival_day, arrival_month, arrival_year,
               departure_day, departure_month, departure_year,
        input  ready
    );
    modport sink (
        input  valid, arrival_day, arrival_month, arrival_year,
               departure_day, departure_month, departure_year,
        output ready
    );
endinterface

interface sdrc_out_if;
    logic                               valid;
    logic                               ready;
    sdrc_pkg::t_status                  status;
    logic [sdrc_pkg::SERIAL_W-1:0]      day_count;

    modport source (output valid, status, day_count, input ready);
    modport sink   (input valid, status, day_count, output ready);
endinterface

FILE: rtl/sdrc_date_eval.sv
// Date unit: Gregorian validity check and serial day number of one date.
module sdrc_date_eval (
    input  logic [sdrc_pkg::DAY_W-1:0]   i_day,
    input  logic [sdrc_pkg::MONTH_W-1:0] i_month,
    input  logic [sdrc_pkg::YEAR_W-1:0]  i_year,
    input  logic [sdrc_pkg::YEAR_W-1:0]  i_floor_year,
    output sdrc_pkg::t_date_eval         o_eval
);

    logic [sdrc_pkg::DIV100_PROD_W-1:0] w_prod;
    logic [sdrc_pkg::CENT_W-1:0]        w_cent;
    logic [sdrc_pkg::CENT_W-1:0]        w_cent_adj;
    logic [sdrc_pkg::YEAR_W-1:0]        w_hund;
    logic [sdrc_pkg::YEAR_W-1:0]        w_year_adj;
    logic                               w_cent_year;
    logic                               w_leap;
    logic                               w_early;

    // Century count through a reciprocal multiply.
    assign w_prod      = sdrc_pkg::DIV100_PROD_W'(i_year) * sdrc_pkg::DIV100_MUL;
    assign w_cent      = w_prod[sdrc_pkg::DIV100_PROD_W-1:sdrc_pkg::DIV100_SHIFT];
    assign w_hund      = sdrc_pkg::YEAR_W'(w_cent) * sdrc_pkg::CENTURY;
    assign w_cent_year = (w_hund == i_year);

    // Leap year: by 4 and not by 100, or by 400.
    assign w_leap = ((i_year[1:0] == 2'b00) && !w_cent_year)
                  || (w_cent_year && (w_cent[1:0] == 2'b00));

    // January and February belong to the previous year in the serial count.
    // The century count of that year drops by one only on a century year.
    assign w_early    = (i_month < 4'd3);
    assign w_year_adj = i_year - sdrc_pkg::YEAR_W'(w_early);
    assign w_cent_adj = w_cent - sdrc_pkg::CENT_W'(w_early && w_cent_year);

    // Validity against the year window and the month lengths.
    assign o_eval.valid = (i_year >= i_floor_year) && (i_year <= sdrc_pkg::YEAR_MAX)
                        && (i_month >= 4'd1) && (i_month <= 4'd12)
                        && (i_day >= 5'd1)
                        && (i_day <= sdrc_pkg::month_days(i_month, w_leap));

    // Serial day number: 365*y + y/4 - y/100 + y/400 + month term + day.
    assign o_eval.serial = sdrc_pkg::SERIAL_W'(w_year_adj) * sdrc_pkg::DAYS_YEAR
                         + sdrc_pkg::SERIAL_W'(w_year_adj[sdrc_pkg::YEAR_W-1:2])
                         - sdrc_pkg::SERIAL_W'(w_cent_adj)
                         + sdrc_pkg::SERIAL_W'(w_cent_adj[sdrc_pkg::CENT_W-1:2])
                         + sdrc_pkg::SERIAL_W'(sdrc_pkg::month_term(i_month))
                         + sdrc_pkg::SERIAL_W'(i_day);

endmodule

FILE: rtl/stay_date_range_checker_unit.sv
// Top level of the stay date range checker: three-stage date pair pipeline.
//
// The block takes one arrival/departure date pair per cycle and returns one
// result word per pair, in order: a status (ok, arrival invalid, departure
// invalid, departure before arrival) and the number of days of the stay,
// which is zero on any error. A pair passes through three stages in turn
// (input register, date evaluation register, result register), and these
// share one advance enable, so the block keeps one pair per cycle for as
// long as the result side takes a word per cycle and holds all stages when a
// result waits. The minimum year register resets to 2024, a value of zero
// acts as one, and it should be written only while no pair is in flight.
module stay_date_range_checker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sdrc_pkg::YEAR_W-1:0]   i_cfg_wdata,
    sdrc_in_if.sink                       i_in,
    sdrc_out_if.source                    o_out
);

    logic [sdrc_pkg::YEAR_W-1:0]   r_min_year;
    logic [sdrc_pkg::YEAR_W-1:0]   w_floor_year;
    logic                          w_adv;

    logic                          r_in_valid;
    logic [sdrc_pkg::DAY_W-1:0]    r_arr_day;
    logic [sdrc_pkg::MONTH_W-1:0]  r_arr_month;
    logic [sdrc_pkg::YEAR_W-1:0]   r_arr_year;
    logic [sdrc_pkg::DAY_W-1:0]    r_dep_day;
    logic [sdrc_pkg::MONTH_W-1:0]  r_dep_month;
    logic [sdrc_pkg::YEAR_W-1:0]   r_dep_year;

    sdrc_pkg::t_date_eval          w_arr_eval;
    sdrc_pkg::t_date_eval          w_dep_eval;

    logic                          r_mid_valid;
    sdrc_pkg::t_status             r_mid_status;
    sdrc_pkg::t_status             n_mid_status;
    logic [sdrc_pkg::SERIAL_W-1:0] r_arr_serial;
    logic [sdrc_pkg::SERIAL_W-1:0] r_dep_serial;

    logic                          r_out_valid;
    sdrc_pkg::t_status             r_out_status;
    sdrc_pkg::t_status             n_out_status;
    logic [sdrc_pkg::SERIAL_W-1:0] r_out_count;
    logic [sdrc_pkg::SERIAL_W-1:0] n_out_count;

    // Minimum year register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= sdrc_pkg::MIN_YEAR_RESET;
        end else if (i_cfg_we) begin
            r_min_year <= i_cfg_wdata;
        end
    end

    assign w_floor_year = (r_min_year == '0) ? sdrc_pkg::YEAR_FLOOR : r_min_year;

    // All stages move together whenever the result register can take a word.
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arr_day   <= i_in.arrival_day;
            r_arr_month <= i_in.arrival_month;
            r_arr_year  <= i_in.arrival_year;
            r_dep_day   <= i_in.departure_day;
            r_dep_month <= i_in.departure_month;
            r_dep_year  <= i_in.departure_year;
        end
    end

    // Date evaluation of both dates.
    sdrc_date_eval u_arr_eval (
        .i_day        (r_arr_day),
        .i_month      (r_arr_month),
        .i_year       (r_arr_year),
        .i_floor_year (w_floor_year),
        .o_eval       (w_arr_eval)
    );

    sdrc_date_eval u_dep_eval (
        .i_day        (r_dep_day),
        .i_month      (r_dep_month),
        .i_year       (r_dep_year),
        .i_floor_year (w_floor_year),
        .o_eval       (w_dep_eval)
    );

    // Validity status, arrival first.
    always_comb begin
        if (!w_arr_eval.valid) begin
            n_mid_status = sdrc_pkg::STATUS_ARR_BAD;
        end else if (!w_dep_eval.valid) begin
            n_mid_status = sdrc_pkg::STATUS_DEP_BAD;
        end else begin
            n_mid_status = sdrc_pkg::STATUS_OK;
        end
    end

    // Evaluation register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (w_adv) begin
            r_mid_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mid_status <= n_mid_status;
            r_arr_serial <= w_arr_eval.serial;
            r_dep_serial <= w_dep_eval.serial;
        end
    end

    // Order check and stay length.
    always_comb begin
        n_out_status = r_mid_status;
        n_out_count  = '0;
        if (r_mid_status == sdrc_pkg::STATUS_OK) begin
            if (r_dep_serial < r_arr_serial) begin
                n_out_status = sdrc_pkg::STATUS_ORDER;
            end else begin
                n_out_count = r_dep_serial - r_arr_serial;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.day_count = r_out_count;

    // An accepted word reaches the evaluation stage's input register.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_valid)
        else $error("accepted date pair did not enter the input register");

    // A word in the evaluation stage moves to the result register on advance.
    a_mid_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && w_adv |=> o_out.valid)
        else $error("evaluated date pair was lost before the result register");

    // Two valid dates can only end as ok or as a wrong order.
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && w_adv && (r_mid_status == sdrc_pkg::STATUS_OK)
        |=> (o_out.status == sdrc_pkg::STATUS_OK)
            || (o_out.status == sdrc_pkg::STATUS_ORDER))
        else $error("valid date pair produced a validity error status");

    // A validity error status always carries a zero day count into the result register.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && w_adv && (r_mid_status != sdrc_pkg::STATUS_OK)
        |=> (o_out.day_count == '0))
        else $error("error status with a nonzero day count");

endmodule

FILE: tb/sv/sdrc_stay_checker.sv
// Checker that predicts and compares the result words of the stay date range checker.
`timescale 1ns / 1ps

module sdrc_stay_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sdrc_pkg::YEAR_W-1:0] i_cfg_wdata,
    sdrc_in_if                          i_pair_mon,
    sdrc_out_if                         i_result_mon,
    output int                          o_pending,
    output int                          o_fail_count
);

    // One predicted result word.
    typedef struct packed {
        sdrc_pkg::t_status             status;
        logic [sdrc_pkg::SERIAL_W-1:0] day_count;
    } t_stay_result;

    // Stays predicted for accepted date pairs, oldest first.
    t_stay_result stay_q[$];
    t_stay_result oldest_stay;
    t_stay_result next_stay;
    logic [sdrc_pkg::YEAR_W-1:0] min_year_q;
    int fail_count = 0;

    assign o_fail_count = fail_count;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: stay check: %s", $time, msg);
        fail_count++;
    endtask

    // Gregorian leap year rule.
    function automatic bit year_is_leap(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    // A date counts only from the minimum year (zero acts as one) up to 9999.
    function automatic bit date_is_valid(input int unsigned day, month, year, min_year);
        int unsigned lowest;
        int unsigned last_day;
        lowest = (min_year == 0) ? 1 : min_year;
        if (year < lowest || year > sdrc_pkg::YEAR_MAX) return 1'b0;
        if (month < 1 || month > 12) return 1'b0;
        case (month)
            4, 6, 9, 11: last_day = 30;
            2:           last_day = year_is_leap(year) ? 29 : 28;
            default:     last_day = 31;
        endcase
        return (day >= 1) && (day <= last_day);
    endfunction

    // Serial day number, counting January and February as months 13 and 14
    // of the year before.
    function automatic int unsigned day_number(input int unsigned day, month, year);
        int unsigned m;
        int unsigned y;
        m = month;
        y = year;
        if (m < 3) begin
            m += 12;
            y -= 1;
        end
        return 365 * y + y / 4 - y / 100 + y / 400 + (153 * m + 2) / 5 + day;
    endfunction

    // Status and stay length for one date pair.
    function automatic t_stay_result predict_stay(
        input int unsigned arr_day, arr_month, arr_year,
        input int unsigned dep_day, dep_month, dep_year,
        input int unsigned min_year
    );
        t_stay_result stay;
        int unsigned  arr_serial;
        int unsigned  dep_serial;
        stay.status    = sdrc_pkg::STATUS_OK;
        stay.day_count = '0;
        if (!date_is_valid(arr_day, arr_month, arr_year, min_year)) begin
            stay.status = sdrc_pkg::STATUS_ARR_BAD;
        end else if (!date_is_valid(dep_day, dep_month, dep_year, min_year)) begin
            stay.status = sdrc_pkg::STATUS_DEP_BAD;
        end else begin
            arr_serial = day_number(arr_day, arr_month, arr_year);
            dep_serial = day_number(dep_day, dep_month, dep_year);
            if (dep_serial < arr_serial) begin
                stay.status = sdrc_pkg::STATUS_ORDER;
            end else begin
                stay.day_count = sdrc_pkg::SERIAL_W'(dep_serial - arr_serial);
            end
        end
        return stay;
    endfunction

    // Track the register, check each result word and predict each date pair word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_year_q <= sdrc_pkg::MIN_YEAR_RESET;
            stay_q.delete();
            o_pending  <= 0;
        end else begin
            if (i_cfg_we) begin
                min_year_q <= i_cfg_wdata;
            end
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (stay_q.size() == 0) begin
                    report_mismatch($sformatf("result word with none expected (status %0d)",
                                              i_result_mon.status));
                end else begin
                    oldest_stay = stay_q.pop_front();
                    if (i_result_mon.status !== oldest_stay.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_result_mon.status, oldest_stay.status));
                    end
                    if (i_result_mon.day_count !== oldest_stay.day_count) begin
                        report_mismatch($sformatf("day_count %0d, expected %0d",
                                                  i_result_mon.day_count,
                                                  oldest_stay.day_count));
                    end
                end
            end
            if (i_pair_mon.valid && i_pair_mon.ready) begin
                next_stay = predict_stay(
                    i_pair_mon.arrival_day, i_pair_mon.arrival_month,
                    i_pair_mon.arrival_year, i_pair_mon.departure_day,
                    i_pair_mon.departure_month, i_pair_mon.departure_year, min_year_q);
                stay_q.insert(stay_q.size(), next_stay);
            end
            o_pending <= stay_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_stay_date_range_checker_unit.sv
// Testbench top: clock, reset, date pair stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module tb_stay_date_range_checker_unit;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES    = 8;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [sdrc_pkg::YEAR_W-1:0] cfg_wdata;
    int                          pending;
    int                          fail_count;
    bit                          no_gaps = 1'b0;

    sdrc_in_if  pair_bus ();
    sdrc_out_if result_bus ();

    stay_date_range_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (pair_bus),
        .o_out       (result_bus)
    );

    sdrc_stay_checker stay_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_pair_mon   (pair_bus),
        .i_result_mon (result_bus),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle cycles before the next word on either side; none during a burst.
    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 15);
    endfunction

    // Offers one date pair word after a random gap and waits until it is taken.
    task automatic send_pair(input int unsigned arr_day, arr_month, arr_year,
                             input int unsigned dep_day, dep_month, dep_year);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            pair_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_bus.valid           <= 1'b1;
        pair_bus.arrival_day     <= sdrc_pkg::DAY_W'(arr_day);
        pair_bus.arrival_month   <= sdrc_pkg::MONTH_W'(arr_month);
        pair_bus.arrival_year    <= sdrc_pkg::YEAR_W'(arr_year);
        pair_bus.departure_day   <= sdrc_pkg::DAY_W'(dep_day);
        pair_bus.departure_month <= sdrc_pkg::MONTH_W'(dep_month);
        pair_bus.departure_year  <= sdrc_pkg::YEAR_W'(dep_year);
        @(posedge i_clk);
        while (!pair_bus.ready) @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_drained();
        pair_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes the minimum year once the pipeline is empty.
    task automatic set_min_year(input int unsigned year);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= sdrc_pkg::YEAR_W'(year);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // A day that is mostly safe for any month, sometimes at a month end.
    function automatic int unsigned pick_day();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    endfunction

    // One random date pair: mostly plausible dates near the minimum year, with
    // some broken fields and some fully random words.
    task automatic send_random_pair(input int unsigned min_year);
        int unsigned lowest, highest, kind, flaw;
        int unsigned ad, am, ay, dd, dm, dy;
        lowest = (min_year == 0) ? 1 : min_year;
        if (lowest > sdrc_pkg::YEAR_MAX) lowest = sdrc_pkg::YEAR_MAX - 20;
        highest = ($urandom_range(0, 7) == 0) ? sdrc_pkg::YEAR_MAX : lowest + 40;
        if (highest > sdrc_pkg::YEAR_MAX) highest = sdrc_pkg::YEAR_MAX;
        ay = $urandom_range(lowest, highest);
        am = $urandom_range(1, 12);
        ad = pick_day();
        case ($urandom_range(0, 9))
            0, 1: begin
                dd = ad;
                dm = am;
                dy = ay;
            end
            2, 3, 4, 5, 6: begin
                dy = ay + $urandom_range(0, 2);
                if (dy > highest) dy = highest;
                dm = $urandom_range(1, 12);
                dd = pick_day();
            end
            default: begin
                dy = $urandom_range(lowest, highest);
                dm = $urandom_range(1, 12);
                dd = pick_day();
            end
        endcase
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            ad = $urandom_range(0, 31);
            am = $urandom_range(0, 15);
            ay = $urandom_range(0, 16383);
            dd = $urandom_range(0, 31);
            dm = $urandom_range(0, 15);
            dy = $urandom_range(0, 16383);
        end else if (kind >= 70) begin
            flaw = $urandom_range(0, 7);
            case (flaw)
                0: ad = ($urandom_range(0, 1) == 0) ? 0 : 31;
                1: am = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
                2: ay = $urandom_range(0, lowest - 1);
                3: ay = $urandom_range(sdrc_pkg::YEAR_MAX + 1, 16383);
                4: dd = ($urandom_range(0, 1) == 0) ? 0 : 31;
                5: dm = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
                6: dy = $urandom_range(0, lowest - 1);
                default: dy = $urandom_range(sdrc_pkg::YEAR_MAX + 1, 16383);
            endcase
        end
        send_pair(ad, am, ay, dd, dm, dy);
    endtask

    // One random phase under a single minimum year, with bursts and pauses.
    task automatic run_phase(input int unsigned min_year, input int unsigned words);
        set_min_year(min_year);
        for (int unsigned i = 0; i < words; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) wait_drained();
            send_random_pair(min_year);
        end
        no_gaps = 1'b0;
    endtask

    // Result side: stall for a random number of cycles before each word.
    initial begin
        int unsigned gap;
        result_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_bus.valid) @(posedge i_clk);
        end
    end

    // Date pair stimulus and verdict.
    initial begin
        i_rst_n                  <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_wdata                <= '0;
        pair_bus.valid           <= 1'b0;
        pair_bus.arrival_day     <= '0;
        pair_bus.arrival_month   <= '0;
        pair_bus.arrival_year    <= '0;
        pair_bus.departure_day   <= '0;
        pair_bus.departure_month <= '0;
        pair_bus.departure_year  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset minimum year of 2024.
        send_pair(1, 1, 2024, 31, 12, 2024);
        send_pair(31, 1, 2024, 29, 2, 2024);     // leap day in a leap year
        send_pair(29, 2, 2025, 1, 3, 2025);      // leap day in a common year
        send_pair(1, 1, 2023, 1, 1, 2024);       // arrival below the minimum year
        send_pair(15, 6, 2030, 14, 6, 2030);     // departure one day early
        send_pair(10, 10, 2030, 10, 10, 2030);   // zero-day stay
        send_pair(1, 5, 2024, 31, 6, 2024);      // day 31 in a 30-day month
        send_pair(29, 2, 2100, 1, 1, 2101);      // century year is not leap
        send_pair(29, 2, 2400, 31, 12, 9999);    // fourth century year is leap
        send_pair(1, 1, 2024, 1, 1, 10000);      // year above 9999
        send_pair(31, 15, 16383, 0, 0, 0);       // arrival fields at their top, departure fields at zero
        send_pair(0, 1, 2024, 1, 1, 2024);
        send_pair(1, 13, 2024, 1, 1, 2025);
        send_pair(31, 12, 9999, 1, 1, 2024);

        // Lowest minimum year: the longest stay and year zero.
        set_min_year(1);
        send_pair(1, 1, 1, 31, 12, 9999);
        send_pair(1, 1, 0, 1, 1, 1);
        send_pair(30, 11, 1, 31, 11, 1);
        send_pair(28, 2, 1900, 1, 3, 1900);
        send_pair(1, 1, 1, 0, 0, 0);

        // A minimum year of zero still rejects year zero.
        set_min_year(0);
        send_pair(1, 1, 0, 1, 1, 1);
        send_pair(1, 1, 1, 1, 3, 4);

        // Minimum years above 9999 reject every date.
        set_min_year(16383);
        send_pair(1, 1, 9999, 31, 12, 9999);
        set_min_year(10000);
        send_pair(1, 1, 9999, 31, 12, 9999);
        send_pair(1, 1, 10000, 1, 1, 10000);

        // Random phases over several register settings.
        run_phase(2024, 250);
        run_phase(1, 200);
        run_phase(0, 150);
        run_phase($urandom_range(1, 9999), 250);
        run_phase(9999, 150);
        run_phase($urandom_range(1, 9999), 250);
        run_phase(10000, 25);
        run_phase(16383, 25);
        run_phase(1, 100);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_stay_date_range_checker_unit: clean");
        end else begin
            $display("tb_stay_date_range_checker_unit: errors");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_stay_date_range_checker_unit: errors");
        $finish;
    end

endmodule
